// File: src/psvm_pkg.sv
// Package for the polyphonic sine voice mixer: voice record, configuration
// record, request and register codes, ring index helper and sine table entry.
// No dependencies.
package psvm_pkg;

  // APB address width: five 32-bit registers at byte addresses 0..16
  localparam int ADDR_W = 5;

  // Request codes on the input channel
  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_ADD    = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  // Register indexes (paddr[4:2])
  localparam logic [2:0] REG_AMPLITUDE = 3'd0;
  localparam logic [2:0] REG_ATTACK    = 3'd1;
  localparam logic [2:0] REG_DECAY     = 3'd2;
  localparam logic [2:0] REG_DROP      = 3'd3;
  localparam logic [2:0] REG_INC       = 3'd4;

  // Full-scale Q1.16 level
  localparam logic [16:0] LEVEL_ONE = 17'd65536;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_TICK
  } ctl_state_t;

  typedef struct packed {
    logic [31:0] phase;
    logic [31:0] incr;
    logic [16:0] attack;
    logic [16:0] decay;
  } voice_t;

  typedef struct packed {
    logic [14:0] amplitude;
    logic [15:0] attack_rate;
    logic [15:0] decay_rate;
    logic [16:0] drop_threshold;
    logic [31:0] inc_per_freq_unit;
  } cfg_t;

  // Result of a finished tick walk
  typedef struct packed {
    logic               done;
    logic signed [15:0] sample;
    logic [6:0]         kept;
  } tick_status_t;

  // (a + b) mod n for a, b < n
  function automatic logic [6:0] ring_add(logic [6:0] a, logic [6:0] b, int unsigned n);
    logic [7:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 8'(n)) s = s - 8'(n);
    return s[6:0];
  endfunction

  // Quarter-wave sine entry k, Q16 polynomial, scaled to 32767
  function automatic logic [14:0] sine_entry(int unsigned k, int unsigned abits);
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] p;
    logic [63:0] e;
    z  = 64'(k) << (18 - abits);
    z2 = (z * z) >> 16;
    p  = 64'd11;
    p  = 64'd307 - ((z2 * p) >> 16);
    p  = 64'd5223 - ((z2 * p) >> 16);
    p  = 64'd42334 - ((z2 * p) >> 16);
    p  = 64'd102944 - ((z2 * p) >> 16);
    p  = (z * p) >> 16;
    e  = (p * 64'd32767 + 64'd32768) >> 16;
    if (e > 64'd32767) e = 64'd32767;
    return e[14:0];
  endfunction

endpackage

// File: src/psvm_req_if.sv
// Request channel: valid/ready handshake carrying one input item.
// Depends on nothing.
interface psvm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [18:0] key_freq;

  modport source (output valid, req_type, key_freq, input ready);
  modport sink   (input valid, req_type, key_freq, output ready);
endinterface

// File: src/psvm_res_if.sv
// Result channel: valid/ready handshake carrying one mixer result.
// Depends on nothing.
interface psvm_res_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               sample_valid;
  logic [6:0]         voice_count;

  modport source (output valid, sample, sample_valid, voice_count, input ready);
  modport sink   (input valid, sample, sample_valid, voice_count, output ready);
endinterface

// File: src/psvm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module psvm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// File: src/psvm_cfg.sv
// APB configuration registers of the mixer.
// Depends on psvm_pkg.
module psvm_cfg import psvm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.amplitude         <= 15'd16384;
      cfg.attack_rate       <= 16'd64880;
      cfg.decay_rate        <= 16'd65530;
      cfg.drop_threshold    <= 17'd66;
      cfg.inc_per_freq_unit <= 32'd366503875;
    end else if (wr) begin
      case (idx)
        REG_AMPLITUDE: cfg.amplitude         <= pwdata[14:0];
        REG_ATTACK:    cfg.attack_rate       <= pwdata[15:0];
        REG_DECAY:     cfg.decay_rate        <= pwdata[15:0];
        REG_DROP:      cfg.drop_threshold    <= pwdata[16:0];
        REG_INC:       cfg.inc_per_freq_unit <= pwdata;
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (idx)
      REG_AMPLITUDE: prdata = {17'd0, cfg.amplitude};
      REG_ATTACK:    prdata = {16'd0, cfg.attack_rate};
      REG_DECAY:     prdata = {16'd0, cfg.decay_rate};
      REG_DROP:      prdata = {15'd0, cfg.drop_threshold};
      REG_INC:       prdata = cfg.inc_per_freq_unit;
      default:       prdata = 32'd0;
    endcase
  end

endmodule

// File: src/psvm_voice_pipe.sv
// Tick pipeline: walks the active voices in age order through the voice RAM,
// mixes their sine contributions and writes survivors back compacted.
// Depends on psvm_pkg.
module psvm_voice_pipe import psvm_pkg::*; #(
  parameter int VOICES         = 8,
  parameter int SINE_ADDR_BITS = 10
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  input  logic [(VOICES > 1 ? $clog2(VOICES) : 1)-1:0] head,
  input  logic [$clog2(VOICES+1)-1:0]             count,
  input  cfg_t                                    cfg,
  output logic [(VOICES > 1 ? $clog2(VOICES) : 1)-1:0] raddr,
  input  voice_t                                  rdata,
  output logic                                    we,
  output logic [(VOICES > 1 ? $clog2(VOICES) : 1)-1:0] waddr,
  output voice_t                                  wdata,
  output tick_status_t                            status
);

  localparam int VW      = VOICES > 1 ? $clog2(VOICES) : 1;
  localparam int CW      = $clog2(VOICES + 1);
  localparam int QUARTER = 1 << (SINE_ADDR_BITS - 2);
  localparam int OW      = SINE_ADDR_BITS - 2;

  // quarter-wave table, constant logic
  logic [14:0] sine_tab [QUARTER+1];
  for (genvar k = 0; k <= QUARTER; k++) begin : g_tab
    assign sine_tab[k] = sine_entry(k, SINE_ADDR_BITS);
  end

  // walk control
  logic          busy;
  logic [CW-1:0] n_voices;
  logic [CW-1:0] rd_idx;
  logic [CW-1:0] wr_cnt;
  logic          issue;
  logic          s1_v, s2_v, s3_v, s4_v, s5_v;

  assign issue = busy && (rd_idx < n_voices);
  assign raddr = VW'(ring_add(7'(head), 7'(rd_idx), VOICES));

  // stage 1 decode of the read voice
  logic [SINE_ADDR_BITS-1:0] s1_addr;
  logic [1:0]                s1_quad;
  logic [OW-1:0]             s1_off;
  logic [OW:0]               s1_idx;
  logic [16:0]               s1_att;
  logic [32:0]               s1_att_p;
  logic [32:0]               s1_dec_p;

  always_comb begin
    s1_addr  = rdata.phase[31 -: SINE_ADDR_BITS];
    s1_quad  = s1_addr[SINE_ADDR_BITS-1 -: 2];
    s1_off   = s1_addr[OW-1:0];
    s1_idx   = s1_quad[0] ? ((OW+1)'(QUARTER) - {1'b0, s1_off}) : {1'b0, s1_off};
    s1_att   = (rdata.attack > LEVEL_ONE) ? LEVEL_ONE : rdata.attack;
    s1_att_p = rdata.attack * cfg.attack_rate;
    s1_dec_p = rdata.decay * cfg.decay_rate;
  end

  // stage registers (payload)
  logic [14:0] s2_mag;
  logic        s2_neg, s3_neg, s4_neg, s5_neg;
  logic [16:0] s2_fac, s3_fac;
  logic [16:0] s2_dec, s3_dec, s4_dec;
  logic [31:0] s2_phase, s2_inc;
  logic [16:0] s2_att, s2_decn;
  logic [29:0] s3_p;
  logic [30:0] s4_p;
  logic [16:0] s5_m;
  logic signed [23:0] acc;
  logic [46:0] s3_prod;
  logic [47:0] s4_prod;
  logic        s2_keep;

  assign s2_keep = s2_decn >= cfg.drop_threshold;
  assign s3_prod = s3_p * s3_fac;
  assign s4_prod = s4_p * s4_dec;

  always_ff @(posedge clk) begin
    // stage 1 -> 2: sine lookup, phase advance, envelope steps
    s2_mag   <= sine_tab[s1_idx];
    s2_neg   <= s1_quad[1];
    s2_fac   <= LEVEL_ONE - s1_att;
    s2_dec   <= rdata.decay;
    s2_phase <= rdata.phase + rdata.incr;
    s2_inc   <= rdata.incr;
    s2_att   <= s1_att_p[32:16];
    s2_decn  <= s1_dec_p[32:16];
    // stage 2 -> 3: gain
    s3_p     <= s2_mag * cfg.amplitude;
    s3_fac   <= s2_fac;
    s3_dec   <= s2_dec;
    s3_neg   <= s2_neg;
    // stage 3 -> 4: attack shaping
    s4_p     <= s3_prod[46:16];
    s4_dec   <= s3_dec;
    s4_neg   <= s3_neg;
    // stage 4 -> 5: decay shaping, back to Q1.15 scale
    s5_m     <= s4_prod[47:31];
    s5_neg   <= s4_neg;
  end

  // survivors written back from logical slot 0 upward
  assign we    = s2_v && s2_keep;
  assign waddr = VW'(ring_add(7'(head), 7'(wr_cnt), VOICES));
  assign wdata = '{phase: s2_phase, incr: s2_inc, attack: s2_att, decay: s2_decn};

  // control and accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
    end else begin
      s1_v <= issue;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
      s5_v <= s4_v;
      if (start) begin
        busy     <= 1'b1;
        n_voices <= count;
        rd_idx   <= '0;
        wr_cnt   <= '0;
        acc      <= '0;
      end else begin
        if (status.done) busy <= 1'b0;
        if (issue) rd_idx <= rd_idx + 1'b1;
        if (we) wr_cnt <= wr_cnt + 1'b1;
        if (s5_v) acc <= acc + (s5_neg ? -$signed({7'd0, s5_m}) : $signed({7'd0, s5_m}));
      end
    end
  end

  // result with saturation
  always_comb begin
    status.done = busy && !start && !issue && !s1_v && !s2_v && !s3_v && !s4_v && !s5_v;
    status.kept = 7'(wr_cnt);
    if (acc > 24'sd32767)       status.sample = 16'sh7fff;
    else if (acc < -24'sd32768) status.sample = -16'sh8000;
    else                        status.sample = acc[15:0];
  end

endmodule

// File: src/polyphonic_sine_voice_mixer.sv
// Top level of the polyphonic sine voice mixer: request control, voice ring
// pointers, voice RAM, configuration port and result register.
// Depends on psvm_pkg, psvm_req_if, psvm_res_if, psvm_ram, psvm_cfg, psvm_voice_pipe.
//
//  channel  dir  handshake         payload
//  din      in   valid/ready       req_type[1:0], key_freq[18:0]
//  dout     out  valid/ready       sample[15:0], sample_valid, voice_count[6:0]
//  apb      in   psel/penable/pready  paddr[4:0], pwdata[31:0], prdata[31:0]
//
// Remove and unused codes give their result in the cycle after the request; an
// add key passes through the ADD state, where the increment multiply and the RAM
// write happen; a tick walks the voices with a one-voice-per-cycle read of the
// voice RAM into a 5-stage multiply pipeline. One request is in work at a time; a
// new one is taken once the result register is free or is being drained.
// Synchronous reset empties the voice ring; RAM contents need no clearing.
module polyphonic_sine_voice_mixer import psvm_pkg::*; #(
  parameter int VOICES         = 8,
  parameter int SINE_ADDR_BITS = 10
) (
  input  logic              clk,
  input  logic              rst,
  psvm_req_if.sink          din,
  psvm_res_if.source        dout,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int VW = VOICES > 1 ? $clog2(VOICES) : 1;
  localparam int CW = $clog2(VOICES + 1);

  cfg_t         cfg;
  ctl_state_t   state, state_next;
  logic [VW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic [18:0]  freq;
  logic         accept;
  logic         full;
  logic         start;
  tick_status_t tick_st;

  // result register
  logic               res_valid;
  logic               res_load;
  logic signed [15:0] res_sample, res_sample_next;
  logic               res_sv, res_sv_next;
  logic [6:0]         res_vc;

  // RAM ports
  logic [VW-1:0] raddr, waddr, pipe_waddr, add_waddr;
  voice_t        rdata, wdata, pipe_wdata;
  logic          we, pipe_we, add_we;
  logic [50:0]   inc_prod;

  psvm_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  psvm_ram #(.WIDTH($bits(voice_t)), .DEPTH(VOICES)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  psvm_voice_pipe #(.VOICES(VOICES), .SINE_ADDR_BITS(SINE_ADDR_BITS)) u_pipe (
    .clk, .rst, .start, .head, .count, .cfg, .raddr, .rdata,
    .we(pipe_we), .waddr(pipe_waddr), .wdata(pipe_wdata), .status(tick_st)
  );

  assign accept   = din.valid && din.ready;
  assign din.ready = (state == ST_IDLE) && (!res_valid || dout.ready);
  assign full     = count == CW'(VOICES);
  assign inc_prod = freq * cfg.inc_per_freq_unit;

  // write port shared by key add and tick write-back
  assign we    = add_we || pipe_we;
  assign waddr = add_we ? add_waddr : pipe_waddr;
  assign wdata = add_we ? voice_t'{phase: 32'd0, incr: inc_prod[47:16], attack: LEVEL_ONE,
                                   decay: LEVEL_ONE}
                        : pipe_wdata;

  // request sequencing
  always_comb begin
    state_next      = state;
    head_next       = head;
    count_next      = count;
    start           = 1'b0;
    add_we          = 1'b0;
    add_waddr       = VW'(ring_add(7'(head), 7'(count), VOICES));
    res_load        = 1'b0;
    res_sample_next = '0;
    res_sv_next     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          case (din.req_type)
            REQ_TICK: begin
              start      = 1'b1;
              state_next = ST_TICK;
            end
            REQ_ADD: state_next = ST_ADD;
            REQ_REMOVE: begin
              if (count != '0) begin
                head_next  = VW'(ring_add(7'(head), 7'd1, VOICES));
                count_next = count - 1'b1;
              end
              res_load = 1'b1;
            end
            default: res_load = 1'b1;
          endcase
        end
      end
      ST_ADD: begin
        add_we = 1'b1;
        if (full) begin
          add_waddr = head;
          head_next = VW'(ring_add(7'(head), 7'd1, VOICES));
        end else begin
          count_next = count + 1'b1;
        end
        res_load   = 1'b1;
        state_next = ST_IDLE;
      end
      ST_TICK: begin
        if (tick_st.done) begin
          count_next      = CW'(tick_st.kept);
          res_sample_next = tick_st.sample;
          res_sv_next     = 1'b1;
          res_load        = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      if (res_load)        res_valid <= 1'b1;
      else if (dout.ready) res_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) freq <= din.key_freq;
    if (res_load) begin
      res_sample <= res_sample_next;
      res_sv     <= res_sv_next;
      res_vc     <= 7'(count_next);
    end
  end

  assign dout.valid        = res_valid;
  assign dout.sample       = res_sample;
  assign dout.sample_valid = res_sv;
  assign dout.voice_count  = res_vc;

endmodule
